@@ rtl/voxel_dag_ray_traversal_macros.svh @@
// Assertion helpers for the voxel DAG ray caster.
// Each macro expands to one labeled concurrent assertion with an active-low
// reset guard.
`ifndef VOXEL_DAG_RAY_TRAVERSAL_MACROS_SVH
`define VOXEL_DAG_RAY_TRAVERSAL_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VDAG_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vdag: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define VDAG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vdag: next-cycle check failed");

`endif

@@ rtl/vdag_pkg.sv @@
`default_nettype none

package vdag_pkg;

    // Memory and stack geometry.
    localparam int NODE_AW   = 16;
    localparam int LEAF_AW   = 12;
    localparam int MAX_DEPTH = 12;
    localparam int SP_W      = 4;

    // Time values: signed, wide enough for +-(2^32 - 1) and the infinite mark 2^32.
    localparam int TW = 34;
    // Cell centers and half sizes stay within 2^28.
    localparam int CW = 30;
    localparam int HW = 29;

    // Cycles from a stable plane select to a valid ray time.
    localparam int TM_LAT = 5;

    localparam int CFG_IW = 1;
    localparam logic [CFG_IW-1:0] CFG_TREE_DEPTH = 1'b0;
    localparam logic [CFG_IW-1:0] CFG_ROOT_ADDR  = 1'b1;

    localparam logic [1:0] CMD_WR_NODE = 2'd0;
    localparam logic [1:0] CMD_WR_LEAF = 2'd1;
    localparam logic [1:0] CMD_TRACE   = 2'd2;

    localparam logic signed [TW-1:0] T_INF = 34'sh1_0000_0000;

    typedef logic signed [TW-1:0] t_time;

    typedef enum logic [1:0] {
        PL_NEG_HALF,
        PL_POS_HALF,
        PL_CENTER
    } t_plane;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       ld_ray;
        logic       wr_node;
        logic       wr_leaf;
        t_plane     plane;
        logic [1:0] axis;
        logic       root_t0;
        logic       root_t1;
        logic       cell_t;
        logic       rd_desc;
        logic       rd_child;
        logic       rd_leaf;
        logic       push;
        logic       adv;
        logic       pop_rd;
        logic       pop_ld;
        logic       out_ld;
        logic       out_hit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic depth_gt1;
        logic miss_root;
        logic chunk_valid;
        logic leaf_bit;
        logic beyond_exit;
        logic sp_zero;
        logic sp_full;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

@@ rtl/vdag_in_if.sv @@
`default_nettype none

interface vdag_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [15:0]        mem_addr;
    logic [31:0]        mem_data;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] inv_dir_x;
    logic signed [31:0] inv_dir_y;
    logic signed [31:0] inv_dir_z;

    modport source (
        output valid, cmd, mem_addr, mem_data,
        output origin_x, origin_y, origin_z, inv_dir_x, inv_dir_y, inv_dir_z,
        input  ready
    );
    modport sink (
        input  valid, cmd, mem_addr, mem_data,
        input  origin_x, origin_y, origin_z, inv_dir_x, inv_dir_y, inv_dir_z,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/vdag_out_if.sv @@
`default_nettype none

interface vdag_out_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [31:0] hit_distance;
    logic [1:0]  normal_axis;
    logic        normal_positive;

    modport source (
        output valid, hit, hit_distance, normal_axis, normal_positive,
        input  ready
    );
    modport sink (
        input  valid, hit, hit_distance, normal_axis, normal_positive,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/vdag_ctrl.sv @@
`default_nettype none

module vdag_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic [1:0]      i_in_cmd,
    output logic                 o_in_ready,
    output vdag_pkg::t_cmd       o_cmd,
    input  wire vdag_pkg::t_sts  i_sts
);
    import vdag_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROOT0,
        S_ROOT1,
        S_ROOTCHK,
        S_CELL,
        S_LOOP,
        S_DESC,
        S_CHILD,
        S_LEAF,
        S_ADV,
        S_POP,
        S_OUT
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_axis, n_axis;
    logic [2:0] r_cnt, n_cnt;
    logic       r_res_hit, n_res_hit;
    logic       w_tm_done;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_tm_done  = (r_cnt == 3'(TM_LAT));

    // Next state and command decode.
    always_comb begin
        n_state   = r_state;
        n_axis    = r_axis;
        n_cnt     = r_cnt;
        n_res_hit = r_res_hit;
        o_cmd       = '0;
        o_cmd.plane = PL_CENTER;
        o_cmd.axis  = r_axis;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_res_hit = 1'b0;
                    n_state   = S_OUT;
                    case (i_in_cmd)
                        CMD_WR_NODE: o_cmd.wr_node = 1'b1;
                        CMD_WR_LEAF: o_cmd.wr_leaf = 1'b1;
                        CMD_TRACE: begin
                            o_cmd.ld_ray = 1'b1;
                            n_axis  = 2'd0;
                            n_cnt   = 3'd0;
                            n_state = S_ROOT0;
                        end
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_ROOT0, S_ROOT1, S_CELL: begin
                case (r_state)
                    S_ROOT0: o_cmd.plane = PL_NEG_HALF;
                    S_ROOT1: o_cmd.plane = PL_POS_HALF;
                    default: o_cmd.plane = PL_CENTER;
                endcase
                if (w_tm_done) begin
                    n_cnt = 3'd0;
                    case (r_state)
                        S_ROOT0: o_cmd.root_t0 = 1'b1;
                        S_ROOT1: o_cmd.root_t1 = 1'b1;
                        default: o_cmd.cell_t  = 1'b1;
                    endcase
                    if (r_axis == 2'd2) begin
                        n_axis = 2'd0;
                        case (r_state)
                            S_ROOT0: n_state = S_ROOT1;
                            S_ROOT1: n_state = S_ROOTCHK;
                            default: n_state = S_LOOP;
                        endcase
                    end else begin
                        n_axis = r_axis + 2'd1;
                    end
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            S_ROOTCHK: begin
                if (i_sts.miss_root) begin
                    n_res_hit = 1'b0;
                    n_state   = S_OUT;
                end else begin
                    n_axis  = 2'd0;
                    n_cnt   = 3'd0;
                    n_state = S_CELL;
                end
            end
            S_LOOP: begin
                if (i_sts.depth_gt1) begin
                    o_cmd.rd_desc = 1'b1;
                    n_state = S_DESC;
                end else begin
                    o_cmd.rd_leaf = 1'b1;
                    n_state = S_LEAF;
                end
            end
            S_DESC: begin
                if (i_sts.chunk_valid) begin
                    o_cmd.rd_child = 1'b1;
                    n_state = S_CHILD;
                end else begin
                    n_state = S_ADV;
                end
            end
            S_CHILD: begin
                if (!i_sts.sp_full) begin
                    o_cmd.push = 1'b1;
                    n_axis  = 2'd0;
                    n_cnt   = 3'd0;
                    n_state = S_CELL;
                end else begin
                    n_state = S_ADV;
                end
            end
            S_LEAF: begin
                if (i_sts.leaf_bit) begin
                    n_res_hit = 1'b1;
                    n_state   = S_OUT;
                end else begin
                    n_state = S_ADV;
                end
            end
            S_ADV: begin
                if (i_sts.beyond_exit) begin
                    if (i_sts.sp_zero) begin
                        n_res_hit = 1'b0;
                        n_state   = S_OUT;
                    end else begin
                        o_cmd.pop_rd = 1'b1;
                        n_state = S_POP;
                    end
                end else begin
                    o_cmd.adv = 1'b1;
                    n_state = S_LOOP;
                end
            end
            S_POP: begin
                o_cmd.pop_ld = 1'b1;
                n_state = S_ADV;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ld  = 1'b1;
                    o_cmd.out_hit = r_res_hit;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and registered control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_axis    <= 2'd0;
            r_cnt     <= 3'd0;
            r_res_hit <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_axis    <= n_axis;
            r_cnt     <= n_cnt;
            r_res_hit <= n_res_hit;
        end
    end

endmodule

`default_nettype wire

@@ rtl/vdag_dp.sv @@
`default_nettype none

module vdag_dp (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [vdag_pkg::CFG_IW-1:0] i_cfg_idx,
    input  wire logic [15:0]                 i_cfg_data,
    input  wire logic [15:0]                 i_mem_addr,
    input  wire logic [31:0]                 i_mem_data,
    input  wire logic signed [31:0]          i_origin_x,
    input  wire logic signed [31:0]          i_origin_y,
    input  wire logic signed [31:0]          i_origin_z,
    input  wire logic signed [31:0]          i_inv_dir_x,
    input  wire logic signed [31:0]          i_inv_dir_y,
    input  wire logic signed [31:0]          i_inv_dir_z,
    input  wire vdag_pkg::t_cmd              i_cmd,
    output vdag_pkg::t_sts                   o_sts,
    input  wire logic                        i_out_ready,
    output logic                             o_out_valid,
    output logic                             o_hit,
    output logic [31:0]                      o_hit_distance,
    output logic [1:0]                       o_normal_axis,
    output logic                             o_normal_positive
);
    import vdag_pkg::*;

    typedef struct packed {
        logic [NODE_AW-1:0] node;
        t_time              t2;
        t_time              t1;
        t_time              t0;
        t_time              t_exit;
        logic [2:0]         oct;
    } t_frame;

    // Configuration registers.
    logic [3:0]         r_tree_depth;
    logic [NODE_AW-1:0] r_root_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tree_depth <= 4'd1;
            r_root_addr  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TREE_DEPTH: r_tree_depth <= i_cfg_data[3:0];
                CFG_ROOT_ADDR:  r_root_addr  <= i_cfg_data[NODE_AW-1:0];
                default: ;
            endcase
        end
    end

    // Memories.
    logic [31:0]        r_node_mem [2**NODE_AW];
    logic [7:0]         r_leaf_mem [2**LEAF_AW];
    t_frame             r_stack [MAX_DEPTH];
    logic [31:0]        r_rd;
    logic [7:0]         r_leaf;
    t_frame             r_frame;

    // Ray and traversal state.
    logic signed [32:0] r_org [3];
    logic [31:0]        r_inv [3];
    logic [2:0]         r_mirror;
    logic [3:0]         r_depth;
    logic [HW-1:0]      r_half;
    logic signed [CW-1:0] r_center [3];
    t_time              r_t [3];
    t_time              r_t_enter;
    t_time              r_t_exit;
    t_time              r_t0best;
    logic [1:0]         r_last_axis;
    logic [NODE_AW-1:0] r_node;
    logic [2:0]         r_oct;
    logic [SP_W-1:0]    r_sp;

    // Input mirroring of negative directions.
    logic signed [31:0] w_org_in [3];
    logic signed [31:0] w_inv_in [3];
    logic signed [32:0] w_org_m [3];
    logic [31:0]        w_inv_m [3];
    logic signed [32:0] w_inv_neg [3];
    logic [3:0]         w_depth_cl;

    assign w_org_in[0] = i_origin_x;
    assign w_org_in[1] = i_origin_y;
    assign w_org_in[2] = i_origin_z;
    assign w_inv_in[0] = i_inv_dir_x;
    assign w_inv_in[1] = i_inv_dir_y;
    assign w_inv_in[2] = i_inv_dir_z;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_inv_neg[k] = -{w_inv_in[k][31], w_inv_in[k]};
            if (w_inv_in[k][31]) begin
                w_org_m[k] = -{w_org_in[k][31], w_org_in[k]};
                w_inv_m[k] = w_inv_neg[k][31:0];
            end else begin
                w_org_m[k] = {w_org_in[k][31], w_org_in[k]};
                w_inv_m[k] = w_inv_in[k];
            end
        end
        if (r_tree_depth == 4'd0) begin
            w_depth_cl = 4'd1;
        end else if (r_tree_depth > 4'(MAX_DEPTH)) begin
            w_depth_cl = 4'(MAX_DEPTH);
        end else begin
            w_depth_cl = r_tree_depth;
        end
    end

    // Ray time pipeline: floor(((plane - org) * inv) / 2^16), saturated.
    t_time              w_plane;
    t_time              w_d;
    t_time              w_dneg;
    logic               r_neg1, r_neg2, r_neg3, r_neg4;
    logic [32:0]        r_md;
    logic [48:0]        r_pl, r_ph;
    logic [64:0]        r_p;
    logic [48:0]        r_q;
    t_time              r_tr;
    logic [64:0]        w_p_rnd;
    logic [31:0]        w_q_sat;

    always_comb begin
        case (i_cmd.plane)
            PL_NEG_HALF: w_plane = -$signed({{(TW-HW){1'b0}}, r_half});
            PL_POS_HALF: w_plane = $signed({{(TW-HW){1'b0}}, r_half});
            PL_CENTER:   w_plane = {{(TW-CW){r_center[i_cmd.axis][CW-1]}},
                                    r_center[i_cmd.axis]};
            default:     w_plane = '0;
        endcase
        w_d     = w_plane - {r_org[i_cmd.axis][32], r_org[i_cmd.axis]};
        w_dneg  = -w_d;
        w_p_rnd = r_neg3 ? (r_p + 65'h0FFFF) : r_p;
        w_q_sat = (|r_q[48:32]) ? 32'hFFFF_FFFF : r_q[31:0];
    end

    always_ff @(posedge i_clk) begin
        r_neg1 <= w_d[TW-1];
        r_md   <= w_d[TW-1] ? w_dneg[32:0] : w_d[32:0];
        r_neg2 <= r_neg1;
        r_pl   <= r_md * r_inv[i_cmd.axis][15:0];
        r_ph   <= r_md * r_inv[i_cmd.axis][31:16];
        r_neg3 <= r_neg2;
        r_p    <= {16'd0, r_pl} + {r_ph, 16'd0};
        r_neg4 <= r_neg3;
        r_q    <= w_p_rnd[64:16];
        r_tr   <= r_neg4 ? -$signed({2'b00, w_q_sat}) : $signed({2'b00, w_q_sat});
    end

    // Nearest pending plane crossing.
    t_time      w_tmin;
    logic [1:0] w_amin;
    logic [2:0] w_true_oct;
    logic [3:0] w_chunk;
    logic [HW-1:0] w_half2;

    always_comb begin
        w_tmin = r_t[0];
        w_amin = 2'd0;
        if (r_t[1] < w_tmin) begin
            w_tmin = r_t[1];
            w_amin = 2'd1;
        end
        if (r_t[2] < w_tmin) begin
            w_tmin = r_t[2];
            w_amin = 2'd2;
        end
        w_true_oct = r_oct ^ r_mirror;
        w_chunk    = r_rd[{w_true_oct, 2'b00} +: 4];
        w_half2    = r_half >> 1;
    end

    // Memory writes and reads.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_node) begin
            r_node_mem[i_mem_addr[NODE_AW-1:0]] <= i_mem_data;
        end
        if (i_cmd.rd_desc) begin
            r_rd <= r_node_mem[r_node];
        end else if (i_cmd.rd_child) begin
            r_rd <= r_node_mem[r_node + NODE_AW'(1) + NODE_AW'(w_chunk[2:0])];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_leaf) begin
            r_leaf_mem[i_mem_addr[LEAF_AW-1:0]] <= i_mem_data[7:0];
        end
        if (i_cmd.rd_leaf) begin
            r_leaf <= r_leaf_mem[r_node[LEAF_AW-1:0]];
        end
    end

    // Frame stack.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_stack[r_sp] <= '{node: r_node, t2: r_t[2], t1: r_t[1], t0: r_t[0],
                               t_exit: r_t_exit, oct: r_oct};
        end
        if (i_cmd.pop_rd) begin
            r_frame <= r_stack[r_sp - SP_W'(1)];
        end
    end

    // Traversal state updates.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_ray) begin
            for (int k = 0; k < 3; k++) begin
                r_org[k]    <= w_org_m[k];
                r_inv[k]    <= w_inv_m[k];
                r_center[k] <= '0;
                r_t[k]      <= T_INF;
            end
            r_mirror    <= {w_inv_in[2][31], w_inv_in[1][31], w_inv_in[0][31]};
            r_depth     <= w_depth_cl;
            r_half      <= HW'(1) << (5'(w_depth_cl) + 5'd16);
            r_t_enter   <= '0;
            r_t_exit    <= T_INF;
            r_t0best    <= '0;
            r_last_axis <= 2'd0;
            r_node      <= r_root_addr;
            r_oct       <= 3'd0;
            r_sp        <= '0;
        end else if (i_cmd.root_t0) begin
            if (r_tr > r_t_enter) begin
                r_t_enter <= r_tr;
            end
            if (i_cmd.axis == 2'd0 || r_tr > r_t0best) begin
                r_t0best    <= r_tr;
                r_last_axis <= i_cmd.axis;
            end
        end else if (i_cmd.root_t1) begin
            if (r_tr < r_t_exit) begin
                r_t_exit <= r_tr;
            end
        end else if (i_cmd.cell_t) begin
            if (r_tr <= r_t_enter) begin
                r_oct[i_cmd.axis] <= 1'b1;
                r_t[i_cmd.axis]   <= T_INF;
            end else begin
                r_t[i_cmd.axis]   <= r_tr;
            end
        end else if (i_cmd.push) begin
            for (int k = 0; k < 3; k++) begin
                r_center[k] <= r_oct[k] ? r_center[k] + $signed({1'b0, w_half2})
                                        : r_center[k] - $signed({1'b0, w_half2});
            end
            r_half  <= w_half2;
            r_node  <= r_rd[NODE_AW-1:0];
            r_depth <= r_depth - 4'd1;
            r_sp    <= r_sp + SP_W'(1);
            r_oct   <= 3'd0;
            if (w_tmin < r_t_exit) begin
                r_t_exit <= w_tmin;
            end
        end else if (i_cmd.adv) begin
            r_oct[w_amin] <= 1'b1;
            r_t[w_amin]   <= T_INF;
            r_t_enter     <= w_tmin;
            r_last_axis   <= w_amin;
        end else if (i_cmd.pop_rd) begin
            r_sp <= r_sp - SP_W'(1);
        end else if (i_cmd.pop_ld) begin
            for (int k = 0; k < 3; k++) begin
                r_center[k] <= r_frame.oct[k] ? r_center[k] - $signed({1'b0, r_half})
                                              : r_center[k] + $signed({1'b0, r_half});
            end
            r_t[0]   <= r_frame.t0;
            r_t[1]   <= r_frame.t1;
            r_t[2]   <= r_frame.t2;
            r_t_exit <= r_frame.t_exit;
            r_oct    <= r_frame.oct;
            r_node   <= r_frame.node;
            r_depth  <= r_depth + 4'd1;
            r_half   <= r_half << 1;
        end
    end

    // Result register: the next trace may run while a result waits here.
    logic r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            if (i_cmd.out_hit) begin
                o_hit             <= 1'b1;
                o_hit_distance    <= r_t_enter[31:0];
                o_normal_axis     <= r_last_axis;
                o_normal_positive <= r_mirror[r_last_axis];
            end else begin
                o_hit             <= 1'b0;
                o_hit_distance    <= 32'hFFFF_FFFF;
                o_normal_axis     <= 2'd0;
                o_normal_positive <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ovalid;

    // Status to the controller.
    always_comb begin
        o_sts.depth_gt1   = (r_depth > 4'd1);
        o_sts.miss_root   = (r_t_exit < r_t_enter);
        o_sts.chunk_valid = w_chunk[3];
        o_sts.leaf_bit    = r_leaf[w_true_oct];
        o_sts.beyond_exit = (w_tmin > r_t_exit);
        o_sts.sp_zero     = (r_sp == '0);
        o_sts.sp_full     = (r_sp == SP_W'(MAX_DEPTH));
        o_sts.out_free    = !r_ovalid || i_out_ready;
    end

endmodule

`default_nettype wire

@@ rtl/voxel_dag_ray_traversal.sv @@
// Loads and unused codes: the output state after the transfer in loads a no-hit result.
// Trace: root clipping is six ray-time evaluations plus one check, and each cell entry three
// more; a node step takes two node reads and a leaf step one leaf read, while a pop reads
// a stack frame and restores it, so latency follows the path.
// One item is in flight at a time; a finished result waits in an output register.
// Reset (synchronous, active low) clears control and sets tree_depth 1, root address 0.
`default_nettype none
`include "voxel_dag_ray_traversal_macros.svh"

module voxel_dag_ray_traversal (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    vdag_in_if.sink                          i_in,
    vdag_out_if.source                       o_out,
    input  wire logic                        i_cfg_we,
    input  wire logic [vdag_pkg::CFG_IW-1:0] i_cfg_idx,
    input  wire logic [15:0]                 i_cfg_data
);
    import vdag_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    // Sequencer.
    vdag_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_cmd   (i_in.cmd),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    assign i_in.ready = w_in_ready;

    // Memories, stack and ray arithmetic.
    vdag_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_mem_addr        (i_in.mem_addr),
        .i_mem_data        (i_in.mem_data),
        .i_origin_x        (i_in.origin_x),
        .i_origin_y        (i_in.origin_y),
        .i_origin_z        (i_in.origin_z),
        .i_inv_dir_x       (i_in.inv_dir_x),
        .i_inv_dir_y       (i_in.inv_dir_y),
        .i_inv_dir_z       (i_in.inv_dir_z),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_out_ready       (o_out.ready),
        .o_out_valid       (o_out.valid),
        .o_hit             (o_out.hit),
        .o_hit_distance    (o_out.hit_distance),
        .o_normal_axis     (o_out.normal_axis),
        .o_normal_positive (o_out.normal_positive)
    );

    // A result is loaded only when the output register can take it.
    `VDAG_ASSERT_SAME(a_out_ld_free, i_clk, i_rst_n, w_cmd.out_ld, w_sts.out_free)
    // A descent needs stack room and a level below the current one.
    `VDAG_ASSERT_SAME(a_push_room, i_clk, i_rst_n, w_cmd.push, !w_sts.sp_full && w_sts.depth_gt1)
    // After a transfer in, the block is busy with that item.
    `VDAG_ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready)

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import vdag_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam longint     TIME_SAT   = 64'sh0_FFFF_FFFF;
    localparam longint     TIME_INF   = 64'sh1_0000_0000;
    localparam int         STALL_MAX  = 4000000;
    localparam int         PHASE_ITEMS = 320;

    typedef struct {
        logic [1:0]         cmd;
        logic [15:0]        addr;
        logic [31:0]        data;
        logic signed [31:0] org [3];
        logic signed [31:0] inv [3];
    } t_ray_item;

    typedef struct {
        logic        hit;
        logic [31:0] distance;
        logic [1:0]  axis;
        logic        pos;
    } t_hit_rec;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_idx;
    logic [15:0] cfg_data;

    vdag_in_if  in_if ();
    vdag_out_if out_if ();

    voxel_dag_ray_traversal u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Shadow copy of the block state.
    logic [31:0] node_mem [65536];
    logic [7:0]  leaf_mem [4096];
    logic [3:0]  depth_reg;
    logic [15:0] root_reg;

    t_hit_rec exp_hits [$];
    int       errors;
    int       send_idle;
    int       recv_idle;
    int       stall_cnt;

    // Tree under test: node addresses, leaf index, and effective depth.
    logic [15:0] tree_nodes [$];
    logic [11:0] leaf_ix;
    int          eff_depth;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // One ray time: floor((plane - org) * inv / 2^16), saturated.
    function automatic longint ray_time(longint plane, longint org, longint inv);
        longint          d;
        bit              neg;
        longint unsigned md, mi, p, q;
        d   = plane - org;
        neg = (d < 0) != (inv < 0);
        md  = (d < 0) ? -d : d;
        mi  = (inv < 0) ? -inv : inv;
        p   = md * mi;
        if (p == 0) return 0;
        q = neg ? (p + 64'hFFFF) >> 16 : p >> 16;
        if (q > TIME_SAT) q = TIME_SAT;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    // First child octant of a cell and its pending plane crossings.
    function automatic int enter_cell(longint ctr [3], longint org [3], longint inv [3],
                                      longint t_in, output longint tp [3]);
        longint tm;
        int     oct;
        oct = 0;
        for (int k = 0; k < 3; k++) begin
            tm = ray_time(ctr[k], org[k], inv[k]);
            if (tm <= t_in) begin
                oct |= 1 << k;
                tp[k] = TIME_INF;
            end else begin
                tp[k] = tm;
            end
        end
        return oct;
    endfunction

    // Walk the tree front to back and return the first occupied voxel.
    function automatic t_hit_rec cast_ray(t_ray_item it);
        longint      org [3], inv [3], ctr [3], tp [3], t0 [3];
        longint      t1, t_in, t_out, half, t_nx;
        longint      s_tp [36], s_out [12];
        logic [15:0] s_node [12];
        int          s_oct [12];
        int          mir, dep, last, oct, toct, sp, ax;
        logic [15:0] node;
        logic [31:0] desc, child;
        logic [3:0]  chunk;
        bit          down;
        t_hit_rec    r;
        r   = '{1'b0, 32'hFFFF_FFFF, 2'd0, 1'b0};
        mir = 0;
        for (int k = 0; k < 3; k++) begin
            org[k] = longint'(it.org[k]);
            inv[k] = longint'(it.inv[k]);
            ctr[k] = 0;
            if (inv[k] < 0) begin
                org[k] = -org[k];
                inv[k] = -inv[k];
                mir |= 1 << k;
            end
        end
        dep = depth_reg;
        if (dep < 1) dep = 1;
        if (dep > MAX_DEPTH) dep = MAX_DEPTH;
        half  = 64'sd1 <<< (dep + 16);
        t_in  = 0;
        t_out = TIME_INF;
        for (int k = 0; k < 3; k++) begin
            t0[k] = ray_time(-half, org[k], inv[k]);
            t1    = ray_time(half, org[k], inv[k]);
            if (t0[k] > t_in) t_in = t0[k];
            if (t1 < t_out) t_out = t1;
        end
        if (t_out < t_in) return r;
        last = 0;
        if (t0[1] > t0[0]) last = 1;
        if (t0[2] > t0[last]) last = 2;
        node = root_reg;
        sp   = 0;
        oct  = enter_cell(ctr, org, inv, t_in, tp);
        while (1) begin
            toct  = (oct ^ mir) & 7;
            down  = 1'b0;
            child = '0;
            if (dep > 1) begin
                desc  = node_mem[node];
                chunk = desc[4*toct +: 4];
                if (chunk[3]) begin
                    child = node_mem[node + 16'd1 + 16'(chunk[2:0])];
                    down  = 1'b1;
                end
            end else if (leaf_mem[node[11:0]][toct]) begin
                r.hit      = 1'b1;
                r.distance = t_in[31:0];
                r.axis     = last[1:0];
                r.pos      = 1'((mir >> last) & 1);
                return r;
            end
            if (down && sp < MAX_DEPTH) begin
                t_nx = tp[0];
                if (tp[1] < t_nx) t_nx = tp[1];
                if (tp[2] < t_nx) t_nx = tp[2];
                s_node[sp] = node;
                for (int k = 0; k < 3; k++) s_tp[3*sp + k] = tp[k];
                s_out[sp] = t_out;
                s_oct[sp] = oct;
                sp++;
                half = half >>> 1;
                for (int k = 0; k < 3; k++)
                    ctr[k] += ((oct >> k) & 1) ? half : -half;
                node = child[15:0];
                if (t_nx < t_out) t_out = t_nx;
                dep--;
                oct = enter_cell(ctr, org, inv, t_in, tp);
                continue;
            end
            // Advance to the next sibling, popping finished frames.
            while (1) begin
                ax   = 0;
                t_nx = tp[0];
                if (tp[1] < t_nx) begin t_nx = tp[1]; ax = 1; end
                if (tp[2] < t_nx) begin t_nx = tp[2]; ax = 2; end
                if (t_nx > t_out) begin
                    if (sp == 0) return r;
                    sp--;
                    dep++;
                    node = s_node[sp];
                    for (int k = 0; k < 3; k++) tp[k] = s_tp[3*sp + k];
                    t_out = s_out[sp];
                    oct   = s_oct[sp];
                    for (int k = 0; k < 3; k++)
                        ctr[k] -= ((oct >> k) & 1) ? half : -half;
                    half = half <<< 1;
                    continue;
                end
                oct |= 1 << ax;
                tp[ax] = TIME_INF;
                t_in   = t_nx;
                last   = ax;
                break;
            end
        end
        return r;
    endfunction

    // Update the shadow state for one accepted item and return its result.
    function automatic t_hit_rec apply_item(t_ray_item it);
        t_hit_rec r;
        r = '{1'b0, 32'hFFFF_FFFF, 2'd0, 1'b0};
        case (it.cmd)
            CMD_WR_NODE: node_mem[it.addr] = it.data;
            CMD_WR_LEAF: leaf_mem[it.addr[11:0]] = it.data[7:0];
            CMD_TRACE:   r = cast_ray(it);
            default:     ;
        endcase
        return r;
    endfunction

    // Send one item; entered and left at a falling edge.
    task automatic send_item(t_ray_item it);
        while ($urandom_range(0, 99) < send_idle) begin
            in_if.valid = 1'b0;
            @(negedge i_clk);
        end
        in_if.cmd       = it.cmd;
        in_if.mem_addr  = it.addr;
        in_if.mem_data  = it.data;
        in_if.origin_x  = it.org[0];
        in_if.origin_y  = it.org[1];
        in_if.origin_z  = it.org[2];
        in_if.inv_dir_x = it.inv[0];
        in_if.inv_dir_y = it.inv[1];
        in_if.inv_dir_z = it.inv[2];
        in_if.valid     = 1'b1;
        do @(posedge i_clk); while (!in_if.ready);
        exp_hits.insert(exp_hits.size(), apply_item(it));
        @(negedge i_clk);
        in_if.valid = 1'b0;
    endtask

    task automatic send_load(logic [1:0] cmd, logic [15:0] addr, logic [31:0] data);
        t_ray_item it;
        it.cmd  = cmd;
        it.addr = addr;
        it.data = data;
        for (int k = 0; k < 3; k++) begin
            it.org[k] = $urandom;
            it.inv[k] = $urandom;
        end
        send_item(it);
    endtask

    task automatic send_ray(logic signed [31:0] ox, logic signed [31:0] oy,
                            logic signed [31:0] oz, logic signed [31:0] vx,
                            logic signed [31:0] vy, logic signed [31:0] vz);
        t_ray_item it;
        it.cmd    = CMD_TRACE;
        it.addr   = 16'($urandom);
        it.data   = $urandom;
        it.org[0] = ox; it.org[1] = oy; it.org[2] = oz;
        it.inv[0] = vx; it.inv[1] = vy; it.inv[2] = vz;
        send_item(it);
    endtask

    // Wait until every expected result has arrived.
    task automatic drain();
        while (exp_hits.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Register writes happen only with the block idle.
    task automatic write_reg(logic [0:0] idx, logic [15:0] data);
        drain();
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(negedge i_clk);
        cfg_we = 1'b0;
        if (idx == CFG_TREE_DEPTH) depth_reg = data[3:0];
        else root_reg = data;
    endtask

    // Build a DAG with one shared node per level, so every followed word is written.
    task automatic build_tree(logic [3:0] depth, logic [15:0] root, bit dense);
        logic [15:0] addr;
        logic [31:0] word;
        write_reg(CFG_TREE_DEPTH, {12'($urandom), depth});
        write_reg(CFG_ROOT_ADDR, root);
        eff_depth = (depth < 1) ? 1 : (depth > MAX_DEPTH) ? MAX_DEPTH : depth;
        tree_nodes.delete();
        leaf_ix = (eff_depth == 1) ? root[11:0] : 12'($urandom);
        addr = root;
        for (int lvl = eff_depth; lvl >= 2; lvl--) begin
            tree_nodes.insert(tree_nodes.size(), addr);
            word = $urandom;
            if (dense) word |= 32'h8888_8888;
            send_load(CMD_WR_NODE, addr, word);
            for (int j = 1; j <= 8; j++) begin
                if (lvl > 2) word = {16'($urandom), 16'(addr + 16'd9)};
                else word = {20'($urandom), leaf_ix};
                send_load(CMD_WR_NODE, addr + 16'(j), word);
            end
            addr = addr + 16'd9;
        end
        word = $urandom;
        if (dense) word[7:0] = word[7:0] | 8'h81 | 8'($urandom);
        send_load(CMD_WR_LEAF, {4'($urandom), leaf_ix}, word);
    endtask

    // A ray near the root cube, mostly aimed at it.
    task automatic random_ray();
        logic signed [31:0] o [3], v [3];
        int                 hs;
        hs = 1 << eff_depth;
        for (int k = 0; k < 3; k++) begin
            o[k] = $signed($urandom_range(0, (6 * hs) << 16)) - ((3 * hs) << 16);
            case ($urandom_range(0, 15))
                0:       v[k] = 0;
                1:       v[k] = 32'sh7FFF_FFFF;
                2:       v[k] = 32'sh8000_0000;
                3:       v[k] = $urandom;
                default: v[k] = (32'sd1 << $urandom_range(8, 26)) | $urandom_range(0, 255);
            endcase
            if (v[k] > 0 && ($urandom_range(0, 3) != 0 ? o[k] > 0 : $urandom_range(0, 1)))
                v[k] = -v[k];
        end
        if ($urandom_range(0, 9) == 0) begin
            for (int k = 0; k < 3; k++) begin
                o[k] = $urandom;
                v[k] = $urandom;
            end
        end
        send_ray(o[0], o[1], o[2], v[0], v[1], v[2]);
    endtask

    // Directed: loads, unused code, extremes of rays and registers.
    task automatic test_directed();
        build_tree(4'd1, 16'h0123, 1'b1);
        send_load(CMD_WR_LEAF, 16'hF123, 32'hFFFF_FF5A);
        send_load(CMD_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
        // Rays straight down each axis: z and x positive, y negative.
        send_ray(32'sh0000_8000, 32'sh0000_4000, -32'sh0005_0000, 0, 0, 32'sh0001_0000);
        send_ray(32'sh0000_8000, 32'sh0005_0000, 32'sh0000_4000, 0, -32'sh0001_0000, 0);
        send_ray(-32'sh0005_0000, -32'sh0000_8000, 32'sh0000_4000, 32'sh0001_0000, 0, 0);
        // Misses the root cube.
        send_ray(32'sh0010_0000, 32'sh0010_0000, 32'sh0010_0000, 32'sh0001_0000,
                 32'sh0001_0000, 32'sh0001_0000);
        // Extreme origins and saturated inverse directions.
        send_ray(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_ray(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
                 32'sh8000_0000, 32'sh8000_0000);
        send_ray(0, 0, 0, 0, 0, 0);
        send_ray(32'sh0000_0001, -32'sh0000_0001, 0, 32'sh0000_0001, -32'sh0000_0001, 1);
        // Depth zero acts as one; depth above the maximum, with a root that wraps.
        build_tree(4'd0, 16'h0ABC, 1'b1);
        send_ray(-32'sh0003_0000, 32'sh0000_3000, 32'sh0000_2000, 32'sh0002_0000, 0, 0);
        build_tree(4'd15, 16'hFFFF, 1'b1);
        send_ray(-32'sh2000_0000, 32'sh0000_1234, -32'sh0000_4321, 32'sh0001_0000,
                 32'sh0000_0100, -32'sh0000_0100);
        send_ray(32'sh1FFF_0000, 32'sh1FFF_0000, 32'sh1FFF_0000, -32'sh0000_2000,
                 -32'sh0000_3000, -32'sh0000_4000);
        build_tree(4'd12, 16'h0000, 1'b1);
        send_ray(32'sh0000_0000, 32'sh0000_0000, -32'sh7000_0000, 32'sh0000_0300,
                 32'sh0000_0200, 32'sh0000_0100);
    endtask

    // Random trees, settings and rays under one idling pattern.
    task automatic test_random(int s_idle, int r_idle);
        int          cnt, n, sel;
        logic [3:0]  dep;
        logic [15:0] a;
        bit          dense;
        send_idle = s_idle;
        recv_idle = r_idle;
        cnt = 0;
        while (cnt < PHASE_ITEMS) begin
            sel = $urandom_range(0, 9);
            if (sel < 6) dep = $urandom_range(1, 4);
            else if (sel < 9) dep = $urandom_range(5, 8);
            else dep = $urandom_range(0, 15);
            dense = (dep > 8) || ($urandom_range(0, 2) != 0);
            a = ($urandom_range(0, 7) == 0) ? 16'hFFFF - 16'($urandom_range(0, 20))
                                            : 16'($urandom);
            build_tree(dep, a, dense);
            cnt += 9 * (eff_depth - 1) + 1;
            n = $urandom_range(30, 60);
            for (int i = 0; i < n; i++) begin
                sel = $urandom_range(0, 19);
                if (sel < 15) begin
                    random_ray();
                end else if (sel < 17 && eff_depth <= 8) begin
                    send_load(CMD_WR_LEAF, {4'($urandom), leaf_ix}, $urandom);
                end else if (sel < 18 && tree_nodes.size() != 0 && eff_depth <= 8) begin
                    send_load(CMD_WR_NODE, tree_nodes[$urandom_range(0, tree_nodes.size() - 1)],
                              $urandom);
                end else if (sel < 19) begin
                    send_load(CMD_UNUSED, 16'($urandom), $urandom);
                end else begin
                    // Hold off until the block has returned everything.
                    drain();
                    random_ray();
                end
            end
            cnt += n;
        end
    endtask

    // Receiver: random ready, and the comparison of every result.
    always @(negedge i_clk) begin
        if (i_rst_n) out_if.ready = ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        t_hit_rec e;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (exp_hits.size() == 0) begin
                $display("%0t: result with none expected: hit %0b dist %h axis %0d pos %0b",
                         $realtime, out_if.hit, out_if.hit_distance, out_if.normal_axis,
                         out_if.normal_positive);
                errors++;
            end else begin
                e = exp_hits.pop_front();
                if (out_if.hit !== e.hit) begin
                    $display("%0t: hit expected %0b actual %0b", $realtime, e.hit, out_if.hit);
                    errors++;
                end
                if (out_if.hit_distance !== e.distance) begin
                    $display("%0t: hit_distance expected %h actual %h", $realtime, e.distance,
                             out_if.hit_distance);
                    errors++;
                end
                if (out_if.normal_axis !== e.axis) begin
                    $display("%0t: normal_axis expected %0d actual %0d", $realtime, e.axis,
                             out_if.normal_axis);
                    errors++;
                end
                if (out_if.normal_positive !== e.pos) begin
                    $display("%0t: normal_positive expected %0b actual %0b", $realtime, e.pos,
                             out_if.normal_positive);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt > STALL_MAX) begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    initial begin
        errors       = 0;
        stall_cnt    = 0;
        send_idle    = 10;
        recv_idle    = 75;
        depth_reg    = 4'd1;
        root_reg     = 16'd0;
        eff_depth    = 1;
        leaf_ix      = '0;
        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = '0;
        cfg_data     = '0;
        in_if.valid  = 1'b0;
        in_if.cmd    = '0;
        in_if.mem_addr = '0;
        in_if.mem_data = '0;
        in_if.origin_x = '0;
        in_if.origin_y = '0;
        in_if.origin_z = '0;
        in_if.inv_dir_x = '0;
        in_if.inv_dir_y = '0;
        in_if.inv_dir_z = '0;
        out_if.ready = 1'b0;
        for (int i = 0; i < 65536; i++) node_mem[i] = '0;
        for (int i = 0; i < 4096; i++) leaf_mem[i] = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random(10, 75);
        test_random(75, 10);
        test_random(0, 0);

        drain();
        repeat (20) @(negedge i_clk);
        if (errors == 0 && exp_hits.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
